[rtl/csvfe_pkg.sv]
// Package for the CSV record/field extractor.
// Holds the character codes, phase and result-kind enums and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csvfe_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int unsigned REC_CMP_W = 25;

    localparam logic [2:0] CFG_TARGET_RECORD = 3'd0;
    localparam logic [2:0] CFG_TARGET_FIELD  = 3'd1;
    localparam logic [2:0] CFG_MAX_LENGTH    = 3'd2;
    localparam logic [2:0] CFG_RECORD_COUNT  = 3'd3;
    localparam logic [2:0] CFG_FIELD_COUNT   = 3'd4;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_SCAN,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        K_BYTE,
        K_OK,
        K_NOTFOUND,
        K_LONG,
        K_RANGE
    } kind_t;

    typedef struct packed {
        logic [15:0] target_record;
        logic [7:0]  target_field;
        logic [11:0] len_lim;
        logic        range_bad;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  out_byte;
        kind_t       kind;
        logic [11:0] value_length;
    } result_t;

endpackage

`default_nettype wire

[rtl/csvfe_cfg.sv]
// Configuration registers of the CSV record/field extractor.
// Derives the length limit and the range-check flag; uses csvfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvfe_cfg #(
    parameter int unsigned MAX_VALUE_BYTES = 4096,
    parameter int unsigned MAX_RECORDS     = 65536
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [16:0]        cfg_data,
    output csvfe_pkg::cfg_t         cfg
);
    import csvfe_pkg::*;

    localparam int unsigned LenCapI =
        ((MAX_VALUE_BYTES - 1) > 4095) ? 4095 : (MAX_VALUE_BYTES - 1);
    localparam logic [11:0]            LEN_CAP = 12'(LenCapI);
    localparam logic [REC_CMP_W-1:0]   REC_CAP = REC_CMP_W'(MAX_RECORDS);

    logic [15:0] target_record_reg;
    logic [7:0]  target_field_reg;
    logic [11:0] max_length_reg;
    logic [16:0] record_count_reg;
    logic [8:0]  field_count_reg;

    logic [REC_CMP_W-1:0] rc_ext;
    logic [REC_CMP_W-1:0] rc_lim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_record_reg <= '0;
            target_field_reg  <= '0;
            max_length_reg    <= 12'd4095;
            record_count_reg  <= '0;
            field_count_reg   <= 9'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TARGET_RECORD: target_record_reg <= cfg_data[15:0];
                CFG_TARGET_FIELD:  target_field_reg  <= cfg_data[7:0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_data[11:0];
                CFG_RECORD_COUNT:  record_count_reg  <= cfg_data;
                CFG_FIELD_COUNT:   field_count_reg   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rc_ext = REC_CMP_W'(record_count_reg);
        rc_lim = (rc_ext > REC_CAP) ? REC_CAP : rc_ext;
        cfg.target_record = target_record_reg;
        cfg.target_field  = target_field_reg;
        cfg.len_lim       = (max_length_reg > LEN_CAP) ? LEN_CAP : max_length_reg;
        cfg.range_bad     = (REC_CMP_W'(target_record_reg) >= rc_lim) ||
                            ({1'b0, target_field_reg} >= field_count_reg);
    end

endmodule

`default_nettype wire

[rtl/csvfe_scan.sv]
// Scan state and per-byte step logic of the CSV record/field extractor.
// Updates record/field/quote/length state once per processed item; uses csvfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csvfe_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_data,
    input  csvfe_pkg::cfg_t         cfg,
    output csvfe_pkg::result_t      res
);
    import csvfe_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] line_reg, line_next;
    logic [7:0]  field_reg, field_next;
    logic        quoted_reg, quoted_next;
    logic [11:0] char_reg, char_next;
    logic        seen_reg, seen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEEK;
            line_reg   <= '0;
            field_reg  <= '0;
            quoted_reg <= 1'b0;
            char_reg   <= '0;
            seen_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            line_reg   <= line_next;
            field_reg  <= field_next;
            quoted_reg <= quoted_next;
            char_reg   <= char_next;
            seen_reg   <= seen_next;
        end
    end

    always_comb begin
        logic        rng_stop;
        logic [12:0] char_inc;
        phase_t      ph;

        phase_next  = phase_reg;
        line_next   = line_reg;
        field_next  = field_reg;
        quoted_next = quoted_reg;
        char_next   = char_reg;
        seen_next   = seen_reg;
        res         = '0;
        rng_stop    = 1'b0;
        char_inc    = {1'b0, char_reg} + 13'd1;
        ph          = phase_reg;

        // first item of a query carries the range check
        if (phase_reg == PH_SEEK && !seen_reg) begin
            seen_next = 1'b1;
            if (cfg.range_bad) begin
                rng_stop   = 1'b1;
                phase_next = PH_DONE;
                res.valid  = 1'b1;
                res.kind   = K_RANGE;
            end
        end

        if (!rng_stop) begin
            if (ph == PH_SEEK && line_reg == cfg.target_record) begin
                ph = PH_SCAN;
            end
            phase_next = ph;
            if (end_of_data) begin
                if (ph == PH_SCAN) begin
                    res.valid = 1'b1;
                    if (field_reg == cfg.target_field) begin
                        res.kind         = K_OK;
                        res.value_length = char_reg;
                    end else begin
                        res.kind = K_NOTFOUND;
                    end
                end else if (ph == PH_SEEK) begin
                    res.valid = 1'b1;
                    res.kind  = K_NOTFOUND;
                end
            end else begin
                unique case (ph)
                    PH_SEEK: begin
                        if (data_byte == CH_LF && line_reg != 16'hFFFF) begin
                            line_next = line_reg + 16'd1;
                        end
                    end
                    PH_SCAN: begin
                        if (char_reg == '0 && data_byte == CH_QUOTE) begin
                            quoted_next = !quoted_reg;
                        end else if (field_reg == cfg.target_field) begin
                            if (data_byte == CH_QUOTE ||
                                (!quoted_reg && (data_byte == CH_COMMA ||
                                 data_byte == CH_LF || data_byte == CH_CR))) begin
                                phase_next       = PH_DONE;
                                res.valid        = 1'b1;
                                res.kind         = K_OK;
                                res.value_length = char_reg;
                            end else begin
                                char_next = char_inc[11:0];
                                res.valid = 1'b1;
                                if (char_inc > {1'b0, cfg.len_lim}) begin
                                    phase_next = PH_DONE;
                                    res.kind   = K_LONG;
                                end else begin
                                    res.kind     = K_BYTE;
                                    res.out_byte = data_byte;
                                end
                            end
                        end else begin
                            if (!quoted_reg && data_byte == CH_COMMA &&
                                field_reg != 8'hFF) begin
                                field_next = field_reg + 8'd1;
                            end
                            if (data_byte == CH_LF) begin
                                phase_next = PH_DONE;
                                res.valid  = 1'b1;
                                res.kind   = K_NOTFOUND;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        // end of data re-arms the query
        if (end_of_data) begin
            phase_next  = PH_SEEK;
            line_next   = '0;
            field_next  = '0;
            quoted_next = 1'b0;
            char_next   = '0;
            seen_next   = 1'b0;
        end
    end

    a_quoted_not_seek: assert property (@(posedge aclk) disable iff (!aresetn)
        quoted_reg |-> phase_reg != PH_SEEK)
        else $error("quote mode set while seeking record");

    a_count_not_seek: assert property (@(posedge aclk) disable iff (!aresetn)
        char_reg != '0 |-> phase_reg != PH_SEEK)
        else $error("value bytes counted while seeking record");

    a_unarmed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (phase_reg == PH_SEEK && line_reg == '0 && field_reg == '0))
        else $error("query not re-armed cleanly");

endmodule

`default_nettype wire

[rtl/csv_record_field_extractor.sv]
// CSV record/field extractor: one input register, single-pass step logic, one result register.
// An accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle while m_ready is high; an item that gives a result waits
// in the input register only while the previous result is still held.
// Reset (aresetn low, synchronous): pipeline emptied, query armed, config back to defaults.
// Uses csvfe_pkg, csvfe_cfg and csvfe_scan.
`timescale 1ns / 1ps
`default_nettype none

module csv_record_field_extractor #(
    parameter int unsigned MAX_VALUE_BYTES = 4096,
    parameter int unsigned MAX_RECORDS     = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [2:0]       m_kind,
    output logic [11:0]      m_value_length,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    import csvfe_pkg::*;

    cfg_t    cfg;
    result_t res;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [2:0]  kind_reg;
    logic [11:0] len_reg;
    logic        out_free;
    logic        adv;

    csvfe_cfg #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
        .MAX_RECORDS     (MAX_RECORDS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csvfe_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (adv),
        .data_byte   (in_byte_reg),
        .end_of_data (in_end_reg),
        .cfg         (cfg),
        .res         (res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign adv      = in_valid_reg && (!res.valid || out_free);
    assign s_ready  = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_end_of_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res.valid) begin
            out_byte_reg <= res.out_byte;
            kind_reg     <= res.kind;
            len_reg      <= res.value_length;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_kind         = kind_reg;
    assign m_value_length = len_reg;

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != K_BYTE) |-> m_out_byte == '0)
        else $error("status item carries a data byte");

    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != K_OK) |-> m_value_length == '0)
        else $error("length set on non-done item");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending result lost");

endmodule

`default_nettype wire
